@@ sv/brta_pkg.sv @@
package brta_pkg;

  localparam int VALUE_BITS          = 64;
  localparam int VALUE_WIDTH_DEFAULT = 64;
  localparam int RADIX_W             = 6;
  localparam int CHAR_W              = 7;
  localparam int DIGIT_COUNT_W       = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd16;
  localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A       = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0]  ASCII_Z       = 7'h5A;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Out-of-range radix codes saturate to the nearest legal base.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT) + ASCII_A;
    end
    return c;
  endfunction

endpackage

@@ sv/brta_if.sv @@
interface brta_value_if import brta_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface brta_char_if import brta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CHAR_W-1:0]        character;
  logic                     last;
  logic [DIGIT_COUNT_W-1:0] digit_count;

  modport source (output valid, output character, output last, output digit_count,
                  input ready);
  modport sink (input valid, input character, input last, input digit_count,
                output ready);
endinterface

@@ sv/brta_div.sv @@
// Restoring divider by a small radix, one quotient bit per cycle.
module brta_div import brta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     radix,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder,
  output div_stat_t              stat
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo;
  logic [RADIX_W-1:0]     rem;
  logic [RADIX_W-1:0]     base;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   done;

  logic [RADIX_W:0]       trial;
  logic                   ge;
  logic [RADIX_W:0]       diff;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, base};
  assign diff  = trial - {1'b0, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= busy && (cnt != CW'(1));
      done <= busy && (cnt == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      base <= radix;
      cnt  <= CW'(VALUE_WIDTH);
    end else if (busy) begin
      quo <= {quo[VALUE_WIDTH-2:0], ge};
      rem <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt <= cnt - CW'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef NO_ASSERTIONS
  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < base)
    else $error("partial remainder not below radix");
`endif

endmodule

@@ sv/brta_digit_buf.sv @@
// Digit store: written least significant first, read back in reverse.
module brta_digit_buf import brta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(VALUE_WIDTH)-1:0] waddr,
  input  logic [RADIX_W-1:0]             wdata,
  input  logic [$clog2(VALUE_WIDTH)-1:0] raddr,
  output logic [RADIX_W-1:0]             rdata
);

  logic [RADIX_W-1:0] mem [VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/binary_to_radix_ascii_core.sv @@
// Converts an unsigned VALUE_WIDTH-bit value into ASCII digits in the radix held by the
// configuration register (2..36; codes 0 and 1 act as 2, codes above 36 act as 36), and
// sends them one character per transfer, most significant digit first, with last set on
// the final digit and the total digit count on every character. Zero gives a single '0'.
// Digits come from one shared restoring divider that produces one quotient bit per cycle.
// Input ready is low from accept until the last character of the value is loaded, and
// the readback stalls while a loaded character waits on ready. Digits are kept in a small
// buffer and read back in reverse, each through the S_EMIT_RD and S_EMIT_LD states.
// The last character may still wait in the output register while the next value is
// accepted.
module binary_to_radix_ascii_core import brta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  brta_value_if.sink         value_ch,
  brta_char_if.source        char_ch
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  state_t                 state;
  state_t                 state_next;
  logic [RADIX_W-1:0]     radix;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [AW-1:0]          rd_idx;
  logic [AW-1:0]          rd_idx_next;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_W-1:0]     div_remainder;
  div_stat_t              div_stat;

  logic                   buf_we;
  logic [RADIX_W-1:0]     buf_rdata;
  logic                   out_load;

  logic                     out_valid;
  logic [CHAR_W-1:0]        out_char;
  logic                     out_last;
  logic [DIGIT_COUNT_W-1:0] out_count;

  brta_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (sat_radix(radix)),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .stat      (div_stat)
  );

  brta_digit_buf #(.VALUE_WIDTH(VALUE_WIDTH)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (count[AW-1:0]),
    .wdata (div_remainder),
    .raddr (rd_idx),
    .rdata (buf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_idx_next    = rd_idx;
    div_start      = 1'b0;
    div_dividend   = div_quotient;
    buf_we         = 1'b0;
    out_load       = 1'b0;
    value_ch.ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (value_ch.valid) begin
          div_start    = 1'b1;
          div_dividend = value_ch.value[VALUE_WIDTH-1:0];
          count_next   = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          buf_we     = 1'b1;
          count_next = count + CW'(1);
          if (div_quotient != '0) begin
            div_start = 1'b1;
          end else begin
            rd_idx_next = count[AW-1:0];
            state_next  = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (!out_valid || char_ch.ready) begin
          out_load = 1'b1;
          if (rd_idx == '0) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx - AW'(1);
            state_next  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (char_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char  <= digit_char(buf_rdata);
      out_last  <= (rd_idx == '0);
      out_count <= DIGIT_COUNT_W'(count);
    end
  end

  assign char_ch.valid       = out_valid;
  assign char_ch.character   = out_char;
  assign char_ch.last        = out_last;
  assign char_ch.digit_count = out_count;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside of conversion");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (value_ch.valid && value_ch.ready) |=> (state == S_DIV) && div_stat.busy)
    else $error("accepted value did not start the divider");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid |-> ((char_ch.character >= ASCII_ZERO && char_ch.character <= ASCII_NINE)
                    || (char_ch.character >= ASCII_A && char_ch.character <= ASCII_Z)))
    else $error("output character outside digit set");
`endif

endmodule

@@ test/binary_to_radix_ascii_core_tb.sv @@
`timescale 1ns / 100ps

module binary_to_radix_ascii_core_tb import brta_pkg::*; ();

  localparam int CLK_PERIOD       = 10;
  localparam int VALUES_PER_PHASE = 44;
  localparam int MAX_GAP          = 12;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 20;
  localparam int PRESSURE_AT      = 1200;
  localparam int PRESSURE_HOLD    = 5000;
  localparam int CYCLE_LIMIT      = 10_000_000;
  localparam int REPORT_LIMIT     = 10;

  typedef struct packed {
    logic [CHAR_W-1:0]        character;
    logic                     last;
    logic [DIGIT_COUNT_W-1:0] digit_count;
  } char_item_t;

  // digits left empty: expectation comes from the predictor
  typedef struct {
    logic [RADIX_W-1:0] radix_code;
    logic [63:0]        value;
    string              digits;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0] cfg_wr_data = '0;

  brta_value_if value_ch ();
  brta_char_if  char_ch ();

  binary_to_radix_ascii_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .value_ch   (value_ch),
    .char_ch    (char_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  char_item_t         pending_chars[$];
  logic [RADIX_W-1:0] radix_code = RADIX_RESET;
  bit                 src_idle = 1'b0;
  bit                 sink_idle = 1'b0;
  int unsigned        cycle_count = 0;
  int unsigned        mismatches = 0;
  int unsigned        values_sent = 0;
  int unsigned        chars_checked = 0;
  int unsigned        settings_used = 0;

  vector_row_t directed_rows[$] = '{
    '{6'd16, 64'd0,                  "0"},
    '{6'd16, 64'd1,                  "1"},
    '{6'd16, 64'd15,                 "F"},
    '{6'd16, 64'd16,                 "10"},
    '{6'd16, 64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"},
    '{6'd16, 64'h8000_0000_0000_0000, "8000000000000000"},
    '{6'd16, 64'h0123_4567_89AB_CDEF, "123456789ABCDEF"},
    '{6'd10, 64'd9,                  "9"},
    '{6'd10, 64'd10,                 "10"},
    '{6'd10, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
    '{6'd2,  64'd0,                  "0"},
    '{6'd2,  64'd5,                  "101"},
    '{6'd2,  64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{6'd2,  64'h8000_0000_0000_0000, ""},
    '{6'd36, 64'd35,                 "Z"},
    '{6'd36, 64'd36,                 "10"},
    '{6'd36, 64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{6'd0,  64'd6,                  "110"},
    '{6'd1,  64'd3,                  "11"},
    '{6'd1,  64'd0,                  "0"},
    '{6'd37, 64'd71,                 "1Z"},
    '{6'd63, 64'd1295,               "ZZ"},
    '{6'd63, 64'd1296,               "100"}
  };

  // last entry is replaced by a random code
  logic [RADIX_W-1:0] phase_codes[8] = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd1, 6'd37, 6'd7, 6'd0};

  function automatic void predict_digits(input logic [63:0] v, input logic [RADIX_W-1:0] code);
    logic [63:0]        base;
    logic [63:0]        rest;
    logic [RADIX_W-1:0] digit_buf[64];
    int                 n;
    char_item_t         it;
    // out-of-range codes clamp to the nearest legal base
    if (code < RADIX_MIN) base = 64'(RADIX_MIN);
    else if (code > RADIX_MAX) base = 64'(RADIX_MAX);
    else base = 64'(code);
    rest = v;
    n = 0;
    do begin
      digit_buf[n] = RADIX_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      if (digit_buf[k] < DECIMAL_LIMIT) it.character = ASCII_ZERO + CHAR_W'(digit_buf[k]);
      else it.character = ASCII_A + CHAR_W'(digit_buf[k] - DECIMAL_LIMIT);
      it.last = (k == 0);
      it.digit_count = DIGIT_COUNT_W'(n);
      pending_chars.push_back(it);
    end
  endfunction

  task automatic offer_value(input logic [63:0] v, input string digits);
    int         gap;
    char_item_t it;
    gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    do @(posedge clk); while (!value_ch.ready);
    if (digits.len() != 0) begin
      for (int i = 0; i < digits.len(); i++) begin
        it.character = CHAR_W'(digits[i]);
        it.last = (i == digits.len() - 1);
        it.digit_count = DIGIT_COUNT_W'(digits.len());
        pending_chars.push_back(it);
      end
    end else begin
      predict_digits(v, radix_code);
    end
    values_sent++;
  endtask

  // called in the step of the last input transfer, so valid drops cleanly
  task automatic wait_idle();
    value_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] code);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_code = code;
    settings_used++;
  endtask

  task automatic check_character(input logic [CHAR_W-1:0] ch, input logic lst,
                                 input logic [DIGIT_COUNT_W-1:0] cnt);
    char_item_t want;
    chars_checked++;
    if (pending_chars.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("Unexpected character 0x%h last=%0b count=%0d", ch, lst, cnt);
      mismatches++;
    end else begin
      want = pending_chars.pop_front();
      if (want.character !== ch || want.last !== lst || want.digit_count !== cnt) begin
        if (mismatches < REPORT_LIMIT)
          $display({"Mismatch on character %0d: expected 0x%h last=%0b count=%0d,",
                    " got 0x%h last=%0b count=%0d"},
                   chars_checked, want.character, want.last, want.digit_count, ch, lst, cnt);
        mismatches++;
      end
    end
  endtask

  // output side: random stalls per character, one long hold-off to back up the block
  initial begin : char_sink
    int stall;
    bit held;
    held = 1'b0;
    char_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && chars_checked >= PRESSURE_AT) begin
        stall = PRESSURE_HOLD;
        held = 1'b1;
      end else begin
        stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        char_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_ch.ready <= 1'b1;
      do @(posedge clk); while (!char_ch.valid);
      check_character(char_ch.character, char_ch.last, char_ch.digit_count);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d characters still expected",
             cycle_count, pending_chars.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int          mode;
    int          len;
    logic [63:0] raw;
    logic [63:0] v;
    logic [RADIX_W-1:0] code;
    value_ch.valid <= 1'b0;
    value_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, first rows run on the reset radix
    foreach (directed_rows[i]) begin
      if (directed_rows[i].radix_code != radix_code) begin
        wait_idle();
        write_radix(directed_rows[i].radix_code);
      end
      src_idle = ($urandom_range(0, 1) != 0);
      sink_idle = ($urandom_range(0, 1) != 0);
      offer_value(directed_rows[i].value, directed_rows[i].digits);
    end

    // random part, one radix per phase
    foreach (phase_codes[p]) begin
      wait_idle();
      code = (p == $size(phase_codes) - 1) ? RADIX_W'($urandom_range(0, 63)) : phase_codes[p];
      write_radix(code);
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (VALUES_PER_PHASE) begin
        mode = $urandom_range(0, 11);
        len = $urandom_range(1, 64);
        raw = {$urandom, $urandom};
        if (mode == 0) v = '0;
        else if (mode == 1) v = '1;
        else v = raw & (~64'd0 >> (64 - len));
        offer_value(v, "");
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d values into %0d characters across %0d radix settings",
             values_sent, chars_checked, settings_used);
    $display("Output held off once for %0d cycles; %0d mismatches", PRESSURE_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
